[design/oled_controller_command_and_ram_write_macros.svh]
// Assertion helpers shared by the blocks of the OLED controller.
// Every check is clocked on i_clk and is switched off while i_rst_n is low.
`ifndef OLED_CONTROLLER_COMMAND_AND_RAM_WRITE_MACROS_SVH
`define OLED_CONTROLLER_COMMAND_AND_RAM_WRITE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OCRW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OCRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ocrw_pkg.sv]
package ocrw_pkg;

    // Default limits of the panel that the RAM can address.
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;
    // Number of jobs that can wait between the decoder and the pixel generator.
    localparam int QUEUE_DEPTH    = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_INVERT_POL   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] PANEL_WIDTH_RST  = 8'd128;
    localparam logic [6:0] PANEL_HEIGHT_RST = 7'd64;

    // Addressing modes.
    localparam logic [1:0] ADDR_HORIZONTAL = 2'd0;
    localparam logic [1:0] ADDR_VERTICAL   = 2'd1;
    localparam logic [1:0] ADDR_PAGE       = 2'd2;

    // Command codes.
    localparam logic [7:0] CMD_ADDR_MODE    = 8'h20;
    localparam logic [7:0] CMD_COL_WINDOW   = 8'h21;
    localparam logic [7:0] CMD_PAGE_WINDOW  = 8'h22;
    localparam logic [7:0] CMD_CONTRAST     = 8'h81;
    localparam logic [7:0] CMD_SEG_NORMAL   = 8'hA0;
    localparam logic [7:0] CMD_SEG_REMAP    = 8'hA1;
    localparam logic [7:0] CMD_DISP_NORMAL  = 8'hA6;
    localparam logic [7:0] CMD_DISP_INVERT  = 8'hA7;
    localparam logic [7:0] CMD_MUX_RATIO    = 8'hA8;
    localparam logic [7:0] CMD_DISP_OFF     = 8'hAE;
    localparam logic [7:0] CMD_DISP_ON      = 8'hAF;
    localparam logic [7:0] CMD_COM_NORMAL   = 8'hC0;
    localparam logic [7:0] CMD_COM_FLIP     = 8'hC8;
    localparam logic [7:0] CMD_DISP_OFFSET  = 8'hD3;
    localparam logic [7:0] CMD_CLOCK_DIV    = 8'hD5;
    localparam logic [7:0] CMD_PRECHARGE    = 8'hD9;
    localparam logic [7:0] CMD_COM_PINS     = 8'hDA;
    localparam logic [7:0] CMD_VCOMH        = 8'hDB;
    localparam logic [7:0] CMD_COL_LOW_FIRST  = 8'h00;
    localparam logic [7:0] CMD_COL_LOW_LAST   = 8'h0F;
    localparam logic [7:0] CMD_COL_HIGH_FIRST = 8'h10;
    localparam logic [7:0] CMD_COL_HIGH_LAST  = 8'h1F;
    localparam logic [7:0] CMD_START_LINE_FIRST = 8'h40;
    localparam logic [7:0] CMD_START_LINE_LAST  = 8'h7F;
    localparam logic [7:0] CMD_PAGE_START_FIRST = 8'hB0;
    localparam logic [7:0] CMD_PAGE_START_LAST  = 8'hB7;

    // One data byte as handed from the decoder to the pixel generator.
    typedef struct packed {
        logic [7:0] mask;       // bits whose pixel falls inside the panel
        logic [6:0] row_base;   // write row of bit 0
        logic [6:0] height;     // effective panel height
        logic       com_flip;
        logic [6:0] pcol;       // physical column, flipping already applied
        logic [7:0] data;
        logic       disp_on;
        logic       disp_inv;
    } t_job;

endpackage

[design/ocrw_decoder.sv]
`include "oled_controller_command_and_ram_write_macros.svh"

module ocrw_decoder #(
    parameter int MAX_WIDTH  = ocrw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ocrw_pkg::MAX_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_valid,
    input  logic              i_is_data,
    input  logic [7:0]        i_byte_value,
    output logic              o_job_push,
    output ocrw_pkg::t_job    o_job
);
    import ocrw_pkg::*;

    logic [7:0] r_panel_width;
    logic [6:0] r_panel_height;
    logic       r_invert_pol;

    logic [1:0] r_addr_mode,  n_addr_mode;
    logic       r_seg_remap,  n_seg_remap;
    logic       r_com_flip,   n_com_flip;
    logic [1:0] r_params_left, n_params_left;
    logic [7:0] r_cur_cmd,    n_cur_cmd;
    logic       r_param_idx,  n_param_idx;
    logic [3:0] r_col_lo,     n_col_lo;
    logic [3:0] r_col_hi,     n_col_hi;
    logic [7:0] r_col_start,  n_col_start;
    logic [7:0] r_col_end,    n_col_end;
    logic [5:0] r_row_start,  n_row_start;
    logic [5:0] r_row_end,    n_row_end;
    logic [7:0] r_wcol,       n_wcol;
    logic [6:0] r_wrow,       n_wrow;
    logic       r_disp_on,    n_disp_on;
    logic       r_disp_inv,   n_disp_inv;

    logic [7:0] eff_w;
    logic [6:0] eff_h;
    logic [8:0] col_inc;
    logic       col_wrap;
    logic [7:0] col_next;
    logic [7:0] row_inc;
    logic       row_wrap;
    logic [6:0] row_next;

    assign eff_w = ({1'b0, r_panel_width} > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : r_panel_width;
    assign eff_h = ({1'b0, r_panel_height} > 8'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT)
                                                            : r_panel_height;

    // Pointer advance after a data byte.
    assign col_inc  = {1'b0, r_wcol} + 9'd1;
    assign col_wrap = col_inc > {1'b0, r_col_end};
    assign col_next = col_wrap ? r_col_start : col_inc[7:0];
    assign row_inc  = {1'b0, r_wrow} + 8'd8;
    assign row_wrap = row_inc > {2'b00, r_row_end};
    assign row_next = row_wrap ? {1'b0, r_row_start} : row_inc[6:0];

    function automatic logic [7:0] nibble_column(input logic [3:0] hi, input logic [3:0] lo,
                                                 input logic [7:0] w);
        logic [7:0] c;
        c = {hi, lo};
        if (w == 8'd0) begin
            c = 8'd0;
        end else if (c >= w) begin
            c = w - 8'd1;
        end
        return c;
    endfunction

    always_comb begin
        logic [2:0] p;
        logic [5:0] e;
        logic [7:0] b;
        n_addr_mode   = r_addr_mode;
        n_seg_remap   = r_seg_remap;
        n_com_flip    = r_com_flip;
        n_params_left = r_params_left;
        n_cur_cmd     = r_cur_cmd;
        n_param_idx   = r_param_idx;
        n_col_lo      = r_col_lo;
        n_col_hi      = r_col_hi;
        n_col_start   = r_col_start;
        n_col_end     = r_col_end;
        n_row_start   = r_row_start;
        n_row_end     = r_row_end;
        n_wcol        = r_wcol;
        n_wrow        = r_wrow;
        n_disp_on     = r_disp_on;
        n_disp_inv    = r_disp_inv;
        b             = i_byte_value;
        p             = i_byte_value[2:0];
        e             = {p, 3'b111};
        o_job_push    = 1'b0;

        o_job.row_base = r_wrow;
        o_job.height   = eff_h;
        o_job.com_flip = r_com_flip;
        o_job.pcol     = r_seg_remap ? 7'(eff_w - 8'd1 - r_wcol) : r_wcol[6:0];
        o_job.data     = i_byte_value;
        o_job.disp_on  = r_disp_on;
        o_job.disp_inv = r_disp_inv;
        for (int k = 0; k < 8; k++) begin
            o_job.mask[k] = (({1'b0, r_wrow} + 8'(k)) < {1'b0, eff_h}) && (r_wcol < eff_w);
        end

        if (i_valid) begin
            if (i_is_data) begin
                o_job_push = (o_job.mask != 8'd0);
                case (r_addr_mode)
                    ADDR_HORIZONTAL: begin
                        if (col_wrap) begin
                            n_wcol = r_col_start;
                            n_wrow = row_next;
                        end else begin
                            n_wcol = col_inc[7:0];
                        end
                    end
                    ADDR_VERTICAL: begin
                        n_wrow = row_next;
                        if (row_wrap) begin
                            n_wcol = col_next;
                        end
                    end
                    default: begin
                        n_wcol = col_next;
                    end
                endcase
            end else if (r_params_left != 2'd0) begin
                n_params_left = r_params_left - 2'd1;
                n_param_idx   = 1'b1;
                case (r_cur_cmd)
                    CMD_ADDR_MODE: begin
                        n_addr_mode = b[1:0];
                    end
                    CMD_COL_WINDOW: begin
                        if (!r_param_idx) begin
                            n_col_start = b;
                            n_wcol      = b;
                        end else begin
                            n_col_end = b;
                        end
                    end
                    CMD_PAGE_WINDOW: begin
                        if (!r_param_idx) begin
                            n_row_start = {p, 3'b000};
                            n_wrow      = {1'b0, p, 3'b000};
                        end else begin
                            if ({1'b0, e} >= eff_h) begin
                                e = (eff_h == 7'd0) ? 6'd0 : 6'(eff_h - 7'd1);
                            end
                            n_row_end = e;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                n_cur_cmd     = b;
                n_param_idx   = 1'b0;
                n_params_left = 2'd0;
                if (b inside {[CMD_START_LINE_FIRST:CMD_START_LINE_LAST]}) begin
                    // Start line is not modeled.
                end else if (b inside {[CMD_PAGE_START_FIRST:CMD_PAGE_START_LAST]}) begin
                    n_wrow = {1'b0, p, 3'b000};
                    n_wcol = r_col_start;
                end else if (b inside {[CMD_COL_LOW_FIRST:CMD_COL_LOW_LAST]}) begin
                    n_col_lo = b[3:0];
                    n_wcol   = nibble_column(r_col_hi, b[3:0], eff_w);
                end else if (b inside {[CMD_COL_HIGH_FIRST:CMD_COL_HIGH_LAST]}) begin
                    n_col_hi = b[3:0];
                    n_wcol   = nibble_column(b[3:0], r_col_lo, eff_w);
                end else begin
                    case (b)
                        CMD_DISP_OFF:    n_disp_on   = 1'b0;
                        CMD_DISP_ON:     n_disp_on   = 1'b1;
                        CMD_DISP_NORMAL: n_disp_inv  = r_invert_pol;
                        CMD_DISP_INVERT: n_disp_inv  = ~r_invert_pol;
                        CMD_SEG_NORMAL:  n_seg_remap = 1'b0;
                        CMD_SEG_REMAP:   n_seg_remap = 1'b1;
                        CMD_COM_NORMAL:  n_com_flip  = 1'b0;
                        CMD_COM_FLIP:    n_com_flip  = 1'b1;
                        CMD_ADDR_MODE:   n_params_left = 2'd1;
                        CMD_COL_WINDOW, CMD_PAGE_WINDOW: n_params_left = 2'd2;
                        CMD_CONTRAST, CMD_MUX_RATIO, CMD_DISP_OFFSET, CMD_CLOCK_DIV,
                        CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOMH: n_params_left = 2'd1;
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_width  <= PANEL_WIDTH_RST;
            r_panel_height <= PANEL_HEIGHT_RST;
            r_invert_pol   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PANEL_WIDTH:  r_panel_width  <= i_cfg_wdata;
                CFG_PANEL_HEIGHT: r_panel_height <= i_cfg_wdata[6:0];
                CFG_INVERT_POL:   r_invert_pol   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_mode   <= ADDR_PAGE;
            r_seg_remap   <= 1'b0;
            r_com_flip    <= 1'b0;
            r_params_left <= 2'd0;
            r_cur_cmd     <= 8'd0;
            r_param_idx   <= 1'b0;
            r_col_lo      <= 4'd0;
            r_col_hi      <= 4'd0;
            r_col_start   <= 8'd0;
            r_col_end     <= PANEL_WIDTH_RST - 8'd1;
            r_row_start   <= 6'd0;
            r_row_end     <= 6'(PANEL_HEIGHT_RST - 7'd1);
            r_wcol        <= 8'd0;
            r_wrow        <= 7'd0;
            r_disp_on     <= 1'b0;
            r_disp_inv    <= 1'b0;
        end else begin
            r_addr_mode   <= n_addr_mode;
            r_seg_remap   <= n_seg_remap;
            r_com_flip    <= n_com_flip;
            r_params_left <= n_params_left;
            r_cur_cmd     <= n_cur_cmd;
            r_param_idx   <= n_param_idx;
            r_col_lo      <= n_col_lo;
            r_col_hi      <= n_col_hi;
            r_col_start   <= n_col_start;
            r_col_end     <= n_col_end;
            r_row_start   <= n_row_start;
            r_row_end     <= n_row_end;
            r_wcol        <= n_wcol;
            r_wrow        <= n_wrow;
            r_disp_on     <= n_disp_on;
            r_disp_inv    <= n_disp_inv;
        end
    end

    `OCRW_ASSERT_SAME(a_push_has_pixels, o_job_push, o_job.mask != 8'd0 && i_is_data,
        "job pushed without a pixel inside the panel")
    `OCRW_ASSERT_NEXT(a_param_count, i_valid && !i_is_data && r_params_left != 2'd0,
        r_param_idx && r_params_left == $past(r_params_left) - 2'd1,
        "parameter count did not step down")
    `OCRW_ASSERT_NEXT(a_page_end_inside,
        i_valid && !i_is_data && r_params_left != 2'd0 && r_cur_cmd == CMD_PAGE_WINDOW
        && r_param_idx,
        {1'b0, r_row_end} < eff_h || eff_h == 7'd0,
        "page end beyond panel height")

endmodule

[design/ocrw_queue.sv]
`include "oled_controller_command_and_ram_write_macros.svh"

module ocrw_queue #(
    parameter int DEPTH = ocrw_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ocrw_pkg::t_job    i_data,
    output logic              o_full,
    input  logic              i_pop,
    output ocrw_pkg::t_job    o_data,
    output logic              o_empty
);
    import ocrw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == CW'(0));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `OCRW_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "queue count out of range")
    `OCRW_ASSERT_SAME(a_no_drop, i_push, !o_full, "job offered to a full queue")
    `OCRW_ASSERT_SAME(a_ptr_match, o_empty || o_full, r_wr_ptr == r_rd_ptr,
        "pointers disagree with the count")

endmodule

[design/ocrw_pixel_gen.sv]
`include "oled_controller_command_and_ram_write_macros.svh"

module ocrw_pixel_gen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ocrw_pkg::t_job    i_job,
    input  logic              i_job_empty,
    output logic              o_job_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [5:0]        o_pixel_row,
    output logic [6:0]        o_pixel_col,
    output logic              o_pixel_on,
    output logic              o_display_enabled,
    output logic              o_display_inverted,
    output logic              o_last
);
    import ocrw_pkg::*;

    logic       r_busy;
    logic [7:0] r_rem;
    t_job       r_job;
    logic       r_out_valid;
    logic [5:0] r_out_row;
    logic [6:0] r_out_col;
    logic       r_out_on;
    logic       r_out_en;
    logic       r_out_inv;
    logic       r_out_last;

    logic [2:0] sel;
    logic [7:0] rem_next;
    logic       sel_last;
    logic       emit;
    logic [7:0] row;
    logic [7:0] prow;

    // Lowest bit still to be written.
    always_comb begin
        sel = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (r_rem[k]) begin
                sel = 3'(k);
            end
        end
    end

    assign rem_next  = r_rem & ~(8'd1 << sel);
    assign sel_last  = (rem_next == 8'd0);
    assign emit      = r_busy && (!r_out_valid || i_pop);
    assign o_job_pop = !i_job_empty && (!r_busy || (emit && sel_last));
    assign row       = {1'b0, r_job.row_base} + {5'd0, sel};
    assign prow      = r_job.com_flip ? ({1'b0, r_job.height} - 8'd1 - row) : row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_busy <= 1'b1;
            end else if (emit && sel_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_rem <= i_job.mask;
            r_job <= i_job;
        end else if (emit) begin
            r_rem <= rem_next;
        end
        if (emit) begin
            r_out_row  <= prow[5:0];
            r_out_col  <= r_job.pcol;
            r_out_on   <= r_job.data[sel];
            r_out_en   <= r_job.disp_on;
            r_out_inv  <= r_job.disp_inv;
            r_out_last <= sel_last;
        end
    end

    assign o_empty            = !r_out_valid;
    assign o_pixel_row        = r_out_row;
    assign o_pixel_col        = r_out_col;
    assign o_pixel_on         = r_out_on;
    assign o_display_enabled  = r_out_en;
    assign o_display_inverted = r_out_inv;
    assign o_last             = r_out_last;

    `OCRW_ASSERT_SAME(a_busy_has_work, r_busy, r_rem != 8'd0, "busy with no pixel left")
    `OCRW_ASSERT_SAME(a_job_not_blank, o_job_pop, i_job.mask != 8'd0, "blank job taken")
    `OCRW_ASSERT_NEXT(a_stay_busy, emit && !sel_last, r_busy, "job dropped before its end")
    `OCRW_ASSERT_SAME(a_row_inside, emit, row < {1'b0, r_job.height},
        "pixel row outside the panel")

endmodule

[design/oled_controller_command_and_ram_write.sv]
// OLED controller front end: command decoding and display RAM pixel writes.
// Input channel: a byte with its command/data flag is offered on i_is_data and
// i_byte_value with push; the transaction completes on a clock edge with push
// high and full low. Command and parameter bytes update the controller state
// and give no result. A data byte gives one pixel write for each of its eight
// bits that lands inside the panel, bit 0 on top, and the last of them has
// o_last set; a byte that lands fully outside the panel gives nothing.
// Output channel: the oldest pixel write is shown while empty is low, and a
// transaction completes on a clock edge with pop high and empty low.
// A data byte passes from the job queue into the generator's job register and
// then, pixel by pixel, into the output register. The pixel generator gives
// one pixel per cycle while the receiver takes them; command bytes are handled
// in the decoder alone and never reach the generator.
// The decoder and the generator are split by a two-entry job queue, so bytes
// keep being accepted while pixels drain, until the queue fills.
// When the receiver stalls, the output register holds its pixel, the generator
// stops, the queue fills and full rises. Reset (synchronous, i_rst_n low)
// empties all queues and restores the panel size, addressing and flags.
// Configuration writes take effect on the next edge; they are meant for times
// when no byte is still being worked on.
module oled_controller_command_and_ram_write #(
    parameter int MAX_WIDTH  = ocrw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ocrw_pkg::MAX_HEIGHT_DEF,
    parameter int Q_DEPTH    = ocrw_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write port.
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    // Byte input channel.
    input  logic       push,
    output logic       full,
    input  logic       i_is_data,
    input  logic [7:0] i_byte_value,
    // Pixel output channel.
    output logic       empty,
    input  logic       pop,
    output logic [5:0] o_pixel_row,
    output logic [6:0] o_pixel_col,
    output logic       o_pixel_on,
    output logic       o_display_enabled,
    output logic       o_display_inverted,
    output logic       o_last
);
    import ocrw_pkg::*;

    logic in_take;
    logic job_push;
    t_job job_in;
    t_job job_out;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // The decoder takes one byte per cycle whenever the queue has room; it
    // never stalls on its own.
    assign full    = q_full;
    assign in_take = push && !q_full;

    ocrw_decoder #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (in_take),
        .i_is_data   (i_is_data),
        .i_byte_value(i_byte_value),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    // Data bytes with at least one visible pixel wait here for the generator.
    ocrw_queue #(
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data (job_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (job_out),
        .o_empty(q_empty)
    );

    // The generator walks the set bits of each job, one pixel per cycle while the
    // receiver takes them, into a single output register.
    ocrw_pixel_gen u_pixel_gen (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (job_out),
        .i_job_empty       (q_empty),
        .o_job_pop         (q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_pixel_row       (o_pixel_row),
        .o_pixel_col       (o_pixel_col),
        .o_pixel_on        (o_pixel_on),
        .o_display_enabled (o_display_enabled),
        .o_display_inverted(o_display_inverted),
        .o_last            (o_last)
    );

endmodule

[test/oled_controller_command_and_ram_write_tb.sv]
module oled_controller_command_and_ram_write_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ocrw_pkg::*;

    // Codes that the block treats as no-ops but that the package does not name.
    localparam logic [7:0] CMD_NOP       = 8'hE3;
    localparam logic [7:0] CMD_UNDEFINED = 8'hFF;
    // Address mode 3 is not a real mode and must act like page addressing.
    localparam logic [1:0] ADDR_PAGE_ALT = 2'd3;
    // Register index with no register behind it; writes to it are dropped.
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    localparam bit BYTE_CMD  = 1'b0;
    localparam bit BYTE_DATA = 1'b1;

    // Cycles to let pass once every pixel has come back, so that a data byte
    // that lands outside the panel has left the pipeline before a register write.
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;

    // One pixel write as it leaves the block.
    typedef struct packed {
        logic [5:0] row;
        logic [6:0] col;
        logic       on;
        logic       en;
        logic       inv;
        logic       last;
    } t_pixel_write;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_wdata;
    logic       push;
    logic       full;
    logic       i_is_data;
    logic [7:0] i_byte_value;
    logic       empty;
    logic       pop;
    logic [5:0] o_pixel_row;
    logic [6:0] o_pixel_col;
    logic       o_pixel_on;
    logic       o_display_enabled;
    logic       o_display_inverted;
    logic       o_last;

    oled_controller_command_and_ram_write dut (.*);

    // Shadow copy of the controller. It is advanced once per accepted byte, in
    // the order the bytes were accepted, so it always reflects the state the
    // block had when it worked on that byte.
    logic [7:0] cfg_width  = PANEL_WIDTH_RST;
    logic [6:0] cfg_height = PANEL_HEIGHT_RST;
    logic       cfg_invert = 1'b0;

    logic [1:0] mode        = ADDR_PAGE;
    logic       seg_remap   = 1'b0;
    logic       com_flip    = 1'b0;
    logic [1:0] params_left = 2'd0;
    logic [7:0] cur_cmd     = 8'd0;
    logic       param_idx   = 1'b0;
    logic [3:0] col_lo      = 4'd0;
    logic [3:0] col_hi      = 4'd0;
    logic [7:0] col_start   = 8'd0;
    logic [7:0] col_end     = PANEL_WIDTH_RST - 8'd1;
    logic [5:0] row_start   = 6'd0;
    logic [5:0] row_end     = 6'(PANEL_HEIGHT_RST - 7'd1);
    logic [7:0] wr_col      = 8'd0;
    logic [6:0] wr_row      = 7'd0;
    logic       disp_on     = 1'b0;
    logic       disp_inv    = 1'b0;

    // Pixel writes that the block still owes, oldest first.
    t_pixel_write pixel_writes_due[$];

    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit rx_hold        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // The panel size registers are wider than the RAM, so both are capped.
    function automatic int eff_width();
        return (int'(cfg_width) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cfg_width);
    endfunction

    function automatic int eff_height();
        return (int'(cfg_height) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(cfg_height);
    endfunction

    // Column given by the two nibble commands, clamped to the last visible column.
    function automatic logic [7:0] nibble_column();
        int w;
        int c;
        w = eff_width();
        c = int'({col_hi, col_lo});
        if (w == 0) c = 0;
        else if (c >= w) c = w - 1;
        return c[7:0];
    endfunction

    // One column step inside the column window, wrapping back to its start.
    function automatic logic [7:0] next_column();
        return (int'(wr_col) + 1 > int'(col_end)) ? col_start : wr_col + 8'd1;
    endfunction

    // Works out what one accepted byte does: command and parameter bytes move
    // the shadow state, data bytes append their pixel writes to the due list.
    function automatic void shadow_byte(input bit is_data, input logic [7:0] b);
        int w;
        int h;
        int row;
        int prow;
        int pcol;
        int r;
        int e;
        int n;
        t_pixel_write px;
        w = eff_width();
        h = eff_height();
        if (is_data == BYTE_CMD && params_left != 2'd0) begin
            // Parameter of a multi-byte command.
            params_left = params_left - 2'd1;
            case (cur_cmd)
                CMD_ADDR_MODE: mode = b[1:0];
                CMD_COL_WINDOW: begin
                    if (!param_idx) begin
                        col_start = b;
                        wr_col = b;
                    end else begin
                        col_end = b;
                    end
                end
                CMD_PAGE_WINDOW: begin
                    // Only the low three bits of a page number count.
                    if (!param_idx) begin
                        row_start = {b[2:0], 3'b000};
                        wr_row = {1'b0, b[2:0], 3'b000};
                    end else begin
                        e = int'(b[2:0]) * 8 + 7;
                        if (e >= h) e = (h == 0) ? 0 : h - 1;
                        row_end = e[5:0];
                    end
                end
                default: begin
                end
            endcase
            param_idx = 1'b1;
        end else if (is_data == BYTE_CMD) begin
            cur_cmd = b;
            param_idx = 1'b0;
            params_left = 2'd0;
            if (b >= CMD_START_LINE_FIRST && b <= CMD_START_LINE_LAST) begin
                // Start line is not modeled by the block.
            end else if (b >= CMD_PAGE_START_FIRST && b <= CMD_PAGE_START_LAST) begin
                wr_row = {1'b0, b[2:0], 3'b000};
                wr_col = col_start;
            end else if (b <= CMD_COL_LOW_LAST) begin
                col_lo = b[3:0];
                wr_col = nibble_column();
            end else if (b >= CMD_COL_HIGH_FIRST && b <= CMD_COL_HIGH_LAST) begin
                col_hi = b[3:0];
                wr_col = nibble_column();
            end else begin
                case (b)
                    CMD_DISP_OFF:    disp_on = 1'b0;
                    CMD_DISP_ON:     disp_on = 1'b1;
                    CMD_DISP_NORMAL: disp_inv = cfg_invert;
                    CMD_DISP_INVERT: disp_inv = ~cfg_invert;
                    CMD_SEG_NORMAL:  seg_remap = 1'b0;
                    CMD_SEG_REMAP:   seg_remap = 1'b1;
                    CMD_COM_NORMAL:  com_flip = 1'b0;
                    CMD_COM_FLIP:    com_flip = 1'b1;
                    CMD_ADDR_MODE:   params_left = 2'd1;
                    CMD_COL_WINDOW, CMD_PAGE_WINDOW: params_left = 2'd2;
                    CMD_CONTRAST, CMD_MUX_RATIO, CMD_DISP_OFFSET, CMD_CLOCK_DIV,
                    CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOMH: params_left = 2'd1;
                    default: begin
                    end
                endcase
            end
        end else begin
            // Data byte: bit 0 is the top pixel; pixels off the panel vanish.
            n = 0;
            for (int i = 0; i < 8; i++) begin
                row = int'(wr_row) + i;
                if (row < h && int'(wr_col) < w) begin
                    prow = com_flip ? h - 1 - row : row;
                    pcol = seg_remap ? w - 1 - int'(wr_col) : int'(wr_col);
                    px.row  = prow[5:0];
                    px.col  = pcol[6:0];
                    px.on   = b[i];
                    px.en   = disp_on;
                    px.inv  = disp_inv;
                    px.last = 1'b0;
                    pixel_writes_due.push_back(px);
                    n++;
                end
            end
            if (n > 0) pixel_writes_due[pixel_writes_due.size() - 1].last = 1'b1;

            // Pointer advance. Mode 3 falls into the page-mode branch.
            case (mode)
                ADDR_HORIZONTAL: begin
                    if (int'(wr_col) + 1 > int'(col_end)) begin
                        wr_col = col_start;
                        r = int'(wr_row) + 8;
                        wr_row = (r > int'(row_end)) ? {1'b0, row_start} : r[6:0];
                    end else begin
                        wr_col = wr_col + 8'd1;
                    end
                end
                ADDR_VERTICAL: begin
                    r = int'(wr_row) + 8;
                    if (r > int'(row_end)) begin
                        wr_row = {1'b0, row_start};
                        wr_col = next_column();
                    end else begin
                        wr_row = r[6:0];
                    end
                end
                default: wr_col = next_column();
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 30) $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic check_pixel(input t_pixel_write got);
        t_pixel_write want;
        if (pixel_writes_due.size() == 0) begin
            flag_mismatch($sformatf("pixel write row %0d col %0d with none due",
                                    got.row, got.col));
            return;
        end
        want = pixel_writes_due.pop_front();
        compare_field("pixel_row", 8'(got.row), 8'(want.row));
        compare_field("pixel_col", 8'(got.col), 8'(want.col));
        compare_field("pixel_on", 8'(got.on), 8'(want.on));
        compare_field("display_enabled", 8'(got.en), 8'(want.en));
        compare_field("display_inverted", 8'(got.inv), 8'(want.inv));
        compare_field("last", 8'(got.last), 8'(want.last));
    endtask

    // The receiver. The outputs are sampled on the falling edge, where they are
    // stable, and the transaction counts at the following rising edge. Pop is
    // then redrawn for the next cycle, held low while a long hold-off is on.
    initial begin : pixel_checker
        t_pixel_write got;
        bit taken;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            taken = i_rst_n && pop && !empty;
            got = {o_pixel_row, o_pixel_col, o_pixel_on, o_display_enabled,
                   o_display_inverted, o_last};
            @(posedge i_clk);
            if (taken) check_pixel(got);
            if (i_rst_n)
                pop <= !(rx_hold || ($urandom_range(99) < recv_stall_pct));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where the transaction happened.
    // Push is left high on return, so a following call keeps the stream dense;
    // whoever stops sending lowers it.
    task automatic send_byte(input bit is_data, input logic [7:0] value);
        bit accepted;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_is_data <= is_data;
        i_byte_value <= value;
        do begin
            @(negedge i_clk);
            accepted = !full;
            @(posedge i_clk);
        end while (!accepted);
        shadow_byte(is_data, value);
    endtask

    // Stops offering bytes and waits until every owed pixel has been popped,
    // then a little longer for bytes that produced no pixel at all.
    task automatic wait_drained();
        push <= 1'b0;
        while (pixel_writes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_PANEL_WIDTH:  cfg_width = value;
            CFG_PANEL_HEIGHT: cfg_height = value[6:0];
            CFG_INVERT_POL:   cfg_invert = value[0];
            default: begin
            end
        endcase
    endtask

    task automatic set_panel(input logic [7:0] width, input logic [6:0] height,
                             input bit polarity);
        wait_drained();
        cfg_write(CFG_PANEL_WIDTH, width);
        cfg_write(CFG_PANEL_HEIGHT, {1'b0, height});
        cfg_write(CFG_INVERT_POL, {7'd0, polarity});
    endtask

    // Mostly data bytes and well-formed command sequences with random content,
    // plus some raw random command bytes and parameter sequences broken up by
    // data bytes.
    task automatic send_random_traffic(input int n_bytes);
        int sent;
        logic [7:0] lo;
        logic [7:0] hi;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(99) < 55) begin
                send_byte(BYTE_DATA, 8'($urandom));
                sent += 1;
            end else if ($urandom_range(99) < 85) begin
                lo = 8'($urandom_range(127));
                hi = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(127, lo));
                case ($urandom_range(9))
                    0: begin
                        send_byte(BYTE_CMD, CMD_ADDR_MODE);
                        send_byte(BYTE_CMD, 8'($urandom));
                        sent += 2;
                    end
                    1: begin
                        send_byte(BYTE_CMD, CMD_COL_WINDOW);
                        send_byte(BYTE_CMD, lo);
                        send_byte(BYTE_CMD, hi);
                        sent += 3;
                    end
                    2: begin
                        send_byte(BYTE_CMD, CMD_PAGE_WINDOW);
                        send_byte(BYTE_CMD, 8'($urandom));
                        send_byte(BYTE_CMD, 8'($urandom));
                        sent += 3;
                    end
                    3: begin
                        send_byte(BYTE_CMD, 8'(CMD_PAGE_START_FIRST + $urandom_range(7)));
                        sent += 1;
                    end
                    4: begin
                        send_byte(BYTE_CMD, 8'(CMD_COL_LOW_FIRST + $urandom_range(15)));
                        sent += 1;
                    end
                    5: begin
                        send_byte(BYTE_CMD, 8'(CMD_COL_HIGH_FIRST + $urandom_range(15)));
                        sent += 1;
                    end
                    6: begin
                        case ($urandom_range(7))
                            0: lo = CMD_DISP_OFF;
                            1: lo = CMD_DISP_ON;
                            2: lo = CMD_DISP_NORMAL;
                            3: lo = CMD_DISP_INVERT;
                            4: lo = CMD_SEG_NORMAL;
                            5: lo = CMD_SEG_REMAP;
                            6: lo = CMD_COM_NORMAL;
                            default: lo = CMD_COM_FLIP;
                        endcase
                        send_byte(BYTE_CMD, lo);
                        sent += 1;
                    end
                    7: begin
                        case ($urandom_range(6))
                            0: lo = CMD_CONTRAST;
                            1: lo = CMD_MUX_RATIO;
                            2: lo = CMD_DISP_OFFSET;
                            3: lo = CMD_CLOCK_DIV;
                            4: lo = CMD_PRECHARGE;
                            5: lo = CMD_COM_PINS;
                            default: lo = CMD_VCOMH;
                        endcase
                        send_byte(BYTE_CMD, lo);
                        send_byte(BYTE_CMD, 8'($urandom));
                        sent += 2;
                    end
                    8: begin
                        if ($urandom_range(1) == 0)
                            send_byte(BYTE_CMD, 8'(CMD_START_LINE_FIRST + $urandom_range(63)));
                        else
                            send_byte(BYTE_CMD, CMD_NOP);
                        sent += 1;
                    end
                    default: begin
                        // A data byte lands between two parameters and must
                        // not consume one.
                        send_byte(BYTE_CMD, CMD_COL_WINDOW);
                        send_byte(BYTE_CMD, lo);
                        send_byte(BYTE_DATA, 8'($urandom));
                        send_byte(BYTE_CMD, hi);
                        sent += 4;
                    end
                endcase
            end else begin
                send_byte(BYTE_CMD, 8'($urandom));
                sent += 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Display flags, flipping, nibble addressing with clamping, page start and
    // commands whose parameter or whole byte is ignored. Page mode, full panel.
    task automatic test_directed_commands();
        send_byte(BYTE_CMD, CMD_DISP_ON);
        send_byte(BYTE_DATA, 8'hFF);
        send_byte(BYTE_DATA, 8'h00);
        send_byte(BYTE_CMD, CMD_DISP_INVERT);
        send_byte(BYTE_CMD, CMD_SEG_REMAP);
        send_byte(BYTE_CMD, CMD_COM_FLIP);
        send_byte(BYTE_DATA, 8'hA5);
        send_byte(BYTE_CMD, CMD_SEG_NORMAL);
        send_byte(BYTE_CMD, CMD_COM_NORMAL);
        send_byte(BYTE_CMD, CMD_DISP_NORMAL);
        // Column 0xFF is past the panel and gets clamped to the last column;
        // the write after it wraps back to the window start.
        send_byte(BYTE_CMD, CMD_COL_LOW_LAST);
        send_byte(BYTE_CMD, CMD_COL_HIGH_LAST);
        send_byte(BYTE_DATA, 8'h5A);
        send_byte(BYTE_CMD, CMD_PAGE_START_LAST);
        send_byte(BYTE_DATA, 8'h81);
        // The parameter of a skipped command looks like display-off but is
        // only a parameter.
        send_byte(BYTE_CMD, CMD_CONTRAST);
        send_byte(BYTE_CMD, CMD_DISP_OFF);
        send_byte(BYTE_CMD, CMD_START_LINE_FIRST);
        send_byte(BYTE_CMD, CMD_NOP);
        send_byte(BYTE_CMD, CMD_UNDEFINED);
        send_byte(BYTE_DATA, 8'h3C);
    endtask

    // Horizontal and vertical addressing inside small windows, including the
    // wrap at both window ends, then the spare mode value.
    task automatic test_addressing_modes();
        send_byte(BYTE_CMD, CMD_ADDR_MODE);
        send_byte(BYTE_CMD, {6'd0, ADDR_HORIZONTAL});
        send_byte(BYTE_CMD, CMD_COL_WINDOW);
        send_byte(BYTE_CMD, 8'd126);
        send_byte(BYTE_CMD, 8'd127);
        // Upper bits of a page number are ignored, so this is page 7.
        send_byte(BYTE_CMD, CMD_PAGE_WINDOW);
        send_byte(BYTE_CMD, 8'hFF);
        send_byte(BYTE_CMD, 8'h07);
        repeat (3) send_byte(BYTE_DATA, 8'($urandom));
        send_byte(BYTE_CMD, CMD_DISP_OFF);
        send_byte(BYTE_CMD, CMD_ADDR_MODE);
        send_byte(BYTE_CMD, {6'd0, ADDR_VERTICAL});
        send_byte(BYTE_CMD, CMD_PAGE_WINDOW);
        send_byte(BYTE_CMD, 8'h06);
        send_byte(BYTE_CMD, 8'h07);
        repeat (3) send_byte(BYTE_DATA, 8'($urandom));
        send_byte(BYTE_CMD, CMD_ADDR_MODE);
        send_byte(BYTE_CMD, {6'd0, ADDR_PAGE_ALT});
        repeat (2) send_byte(BYTE_DATA, 8'($urandom));
    endtask

    // Smallest and largest panel, the polarity register and a write to the
    // unused register index.
    task automatic test_panel_config();
        set_panel(8'd1, 7'd1, 1'b1);
        cfg_write(CFG_UNUSED, 8'hFF);
        send_byte(BYTE_CMD, CMD_DISP_INVERT);
        send_byte(BYTE_CMD, CMD_ADDR_MODE);
        send_byte(BYTE_CMD, {6'd0, ADDR_HORIZONTAL});
        send_byte(BYTE_CMD, CMD_COL_WINDOW);
        send_byte(BYTE_CMD, 8'd0);
        send_byte(BYTE_CMD, 8'd127);
        // The page end gets clamped to the one visible row.
        send_byte(BYTE_CMD, CMD_PAGE_WINDOW);
        send_byte(BYTE_CMD, 8'd0);
        send_byte(BYTE_CMD, 8'd7);
        send_byte(BYTE_DATA, 8'hFF);
        send_byte(BYTE_DATA, 8'h0F);
        send_byte(BYTE_CMD, 8'(CMD_COL_LOW_FIRST + 8'd5));
        send_byte(BYTE_CMD, 8'(CMD_COL_HIGH_FIRST + 8'd3));
        send_byte(BYTE_DATA, 8'hF0);
        set_panel(PANEL_WIDTH_RST, PANEL_HEIGHT_RST, 1'b0);
        send_byte(BYTE_CMD, CMD_DISP_INVERT);
        send_byte(BYTE_CMD, CMD_PAGE_WINDOW);
        send_byte(BYTE_CMD, 8'd0);
        send_byte(BYTE_CMD, 8'd7);
        repeat (2) send_byte(BYTE_DATA, 8'($urandom));
    endtask

    // The receiver stops popping for a long stretch while data bytes keep
    // coming, so the job queue fills and full must hold the sender off.
    task automatic test_backpressure();
        set_panel(PANEL_WIDTH_RST, PANEL_HEIGHT_RST, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_byte(BYTE_CMD, CMD_ADDR_MODE);
        send_byte(BYTE_CMD, {6'd0, ADDR_HORIZONTAL});
        send_byte(BYTE_CMD, CMD_COL_WINDOW);
        send_byte(BYTE_CMD, 8'd0);
        send_byte(BYTE_CMD, 8'd127);
        fork
            begin : receiver_hold
                int held;
                rx_hold = 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            repeat (16) send_byte(BYTE_DATA, 8'($urandom));
        join
    endtask

    // Random traffic in four idling phases, each on its own panel setting.
    task automatic test_random_traffic();
        set_panel(PANEL_WIDTH_RST, PANEL_HEIGHT_RST, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_traffic(31);

        set_panel(8'd96, 7'd48, 1'b1);
        send_idle_pct = 79;
        recv_stall_pct = 0;
        send_random_traffic(31);

        set_panel(8'($urandom_range(128, 1)), 7'($urandom_range(64, 1)), 1'($urandom));
        send_idle_pct = 0;
        recv_stall_pct = 79;
        send_random_traffic(31);

        set_panel(PANEL_WIDTH_RST, PANEL_HEIGHT_RST, 1'b1);
        send_idle_pct = 17;
        recv_stall_pct = 17;
        send_random_traffic(31);
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_PANEL_WIDTH;
        i_cfg_wdata = 8'd0;
        push = 1'b0;
        i_is_data = BYTE_CMD;
        i_byte_value = 8'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_commands();
        test_addressing_modes();
        test_panel_config();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0)
            $display("** oled_controller_command_and_ram_write: PASSED **");
        else
            $display("** oled_controller_command_and_ram_write: FAILED **");
        $finish;
    end

    // Ends a hung run; the limit sits far above the slowest passing run.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** oled_controller_command_and_ram_write: FAILED **");
        $finish;
    end

endmodule
